// ===== rtl/core/gdsc_pkg.sv =====
// ----------------------------------------------------------------------------
// gdsc_pkg
// Shared types, codes and constants of the glyph drop-shadow compositor.
// ----------------------------------------------------------------------------
package gdsc_pkg;

   localparam int MAX_WIDTH_DEFAULT = 64;
   localparam int MIN_WIDTH         = 5;
   localparam int PIX_W             = 8;
   localparam int SHADE_DEPTH       = 256;
   localparam int GLYPH_WIDTH_W     = 7;
   localparam int LAYOUT_W          = 2;
   localparam int CSR_INDEX_W       = 1;
   localparam int CSR_DATA_W        = 7;

   localparam logic [GLYPH_WIDTH_W-1:0] GLYPH_WIDTH_RESET = 7'd8;
   localparam logic [1:0]               ROW_SAT           = 2'd3;
   localparam logic [1:0]               SLOT_LAST         = 2'd2;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_LAYOUT_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLYPH_WIDTH = 1'b1;

   typedef enum logic [LAYOUT_W-1:0] {
      LAYOUT_PLAIN    = 2'd0,
      LAYOUT_TWO_PAGE = 2'd1,
      LAYOUT_HIRES    = 2'd2
   } layout_type;

   typedef enum logic {
      REQ_PIXEL = 1'b0,
      REQ_LOAD  = 1'b1
   } req_kind_type;

   typedef struct packed {
      logic             req_type;
      logic             first_of_glyph;
      logic [PIX_W-1:0] glyph_pixel;
      logic [PIX_W-1:0] back_a;
      logic [PIX_W-1:0] back_b;
      logic [PIX_W-1:0] back_c;
      logic [PIX_W-1:0] back_d;
      logic [PIX_W-1:0] table_index;
      logic [PIX_W-1:0] table_value;
   } req_item_type;

   typedef struct packed {
      logic [PIX_W-1:0] page_one_low;
      logic [PIX_W-1:0] page_one_high;
      logic [PIX_W-1:0] page_two_low;
      logic [PIX_W-1:0] page_two_high;
   } rsp_item_type;

   // top -> raster control
   typedef struct packed {
      logic pix_accept;
      logic s1_advance;
      logic first;
      logic opaque;
   } raster_ctrl_type;

   // raster -> top status
   typedef struct packed {
      logic busy;
      logic shadow;
   } raster_status_type;

endpackage

// ===== rtl/core/gdsc_req_if.sv =====
// ----------------------------------------------------------------------------
// gdsc_req_if
// Valid/ready channel carrying one request item.
// ----------------------------------------------------------------------------
interface gdsc_req_if;
   logic                        valid;
   logic                        ready;
   gdsc_pkg::req_item_type      data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/gdsc_rsp_if.sv =====
// ----------------------------------------------------------------------------
// gdsc_rsp_if
// Valid/ready channel carrying one composited pixel item.
// ----------------------------------------------------------------------------
interface gdsc_rsp_if;
   logic                        valid;
   logic                        ready;
   gdsc_pkg::rsp_item_type      data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/gdsc_ram.sv =====
// ----------------------------------------------------------------------------
// gdsc_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module gdsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-first: a same-cycle write is seen on the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

// ===== rtl/core/gdsc_raster.sv =====
// ----------------------------------------------------------------------------
// gdsc_raster
// Row/column counters, three-row edge line store and shadow decision.
// ----------------------------------------------------------------------------
module gdsc_raster #(
   parameter int MAX_WIDTH = gdsc_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gdsc_pkg::raster_ctrl_type             ctrl,
   input  logic [gdsc_pkg::GLYPH_WIDTH_W-1:0]    glyph_width,
   output gdsc_pkg::raster_status_type           status
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WCW   = ($clog2(MAX_WIDTH + 1) > gdsc_pkg::GLYPH_WIDTH_W) ?
                          $clog2(MAX_WIDTH + 1) : gdsc_pkg::GLYPH_WIDTH_W;
   localparam int DEPTH = 3 * MAX_WIDTH;
   localparam int AW    = $clog2(DEPTH);

   localparam logic [WCW-1:0] MAX_W      = WCW'(MAX_WIDTH);
   localparam logic [WCW-1:0] MIN_W      = WCW'(gdsc_pkg::MIN_WIDTH);
   localparam logic [AW-1:0]  ROW_STRIDE = AW'(MAX_WIDTH);
   localparam logic [AW-1:0]  CLR_LAST   = AW'(DEPTH - 1);

   logic [CW-1:0]  col_ff, col_in;
   logic [1:0]     row_ff, row_in;
   logic [1:0]     slot_ff, slot_in;
   logic           clearing_ff, clearing_in;
   logic [AW-1:0]  clr_addr_ff, clr_addr_in;
   logic           s1_row3_ff, s1_row3_in;
   logic           s1_col2_ff, s1_col2_in;
   logic           s1_col0_ff, s1_col0_in;
   logic           m1_ff, m1_in;
   logic           m2_ff, m2_in;

   logic [WCW-1:0] gw;
   logic [WCW-1:0] width_eff;
   logic [CW-1:0]  col_cur;
   logic [WCW-1:0] col_nxt;
   logic           wrap;
   logic [1:0]     row_base;
   logic [1:0]     slot_base;
   logic [AW-1:0]  edge_addr;
   logic           ram_wr_en;
   logic [AW-1:0]  ram_wr_addr;
   logic           ram_wr_data;
   logic           old_edge;

   // clamp the programmed width into [MIN_WIDTH, MAX_WIDTH]
   always_comb begin
      gw = WCW'(glyph_width);
      if (gw < MIN_W) begin
         width_eff = MIN_W;
      end else if (gw > MAX_W) begin
         width_eff = MAX_W;
      end else begin
         width_eff = gw;
      end
   end

   always_comb begin
      row_base  = ctrl.first ? 2'd0 : row_ff;
      slot_base = ctrl.first ? 2'd0 : slot_ff;
      if (ctrl.first || (WCW'(col_ff) >= width_eff)) begin
         col_cur = '0;
      end else begin
         col_cur = col_ff;
      end
      col_nxt   = WCW'(col_cur) + WCW'(1);
      wrap      = (col_nxt >= width_eff);
      edge_addr = AW'(slot_base) * ROW_STRIDE + AW'(col_cur);
   end

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      slot_in = slot_ff;
      if (ctrl.pix_accept) begin
         if (wrap) begin
            col_in  = '0;
            row_in  = (row_base == gdsc_pkg::ROW_SAT) ? row_base : row_base + 2'd1;
            slot_in = (slot_base == gdsc_pkg::SLOT_LAST) ? 2'd0 : slot_base + 2'd1;
         end else begin
            col_in  = col_nxt[CW-1:0];
            row_in  = row_base;
            slot_in = slot_base;
         end
      end
   end

   // post-reset sweep zeroes the line store
   always_comb begin
      clearing_in = clearing_ff && (clr_addr_ff != CLR_LAST);
      clr_addr_in = clearing_ff ? clr_addr_ff + AW'(1) : clr_addr_ff;
      ram_wr_en   = clearing_ff || ctrl.pix_accept;
      ram_wr_addr = clearing_ff ? clr_addr_ff : edge_addr;
      ram_wr_data = clearing_ff ? 1'b0 : ctrl.opaque;
   end

   // S1 copy of position flags; edge delay line shifts as S1 retires
   always_comb begin
      s1_row3_in = s1_row3_ff;
      s1_col2_in = s1_col2_ff;
      s1_col0_in = s1_col0_ff;
      if (ctrl.pix_accept) begin
         s1_row3_in = (row_base == gdsc_pkg::ROW_SAT);
         s1_col2_in = (WCW'(col_cur) >= WCW'(2));
         s1_col0_in = (col_cur == '0);
      end
      m1_in = m1_ff;
      m2_in = m2_ff;
      if (ctrl.s1_advance) begin
         m2_in = s1_col0_ff ? 1'b0 : m1_ff;
         m1_in = old_edge;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         slot_ff     <= '0;
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
         m1_ff       <= 1'b0;
         m2_ff       <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         slot_ff     <= slot_in;
         clearing_ff <= clearing_in;
         clr_addr_ff <= clr_addr_in;
         m1_ff       <= m1_in;
         m2_ff       <= m2_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_row3_ff <= s1_row3_in;
      s1_col2_ff <= s1_col2_in;
      s1_col0_ff <= s1_col0_in;
   end

   gdsc_ram #(
      .WIDTH (1),
      .DEPTH (DEPTH)
   ) u_edge_ram (
      .clock     (clock),
      .wr_en     (ram_wr_en),
      .wr_addr   (ram_wr_addr),
      .wr_data   (ram_wr_data),
      .rd_en     (ctrl.pix_accept),
      .rd_addr_a (edge_addr),
      .rd_addr_b (edge_addr),
      .rd_data_a (old_edge),
      .rd_data_b ()
   );

   assign status.busy   = clearing_ff;
   assign status.shadow = s1_row3_ff && s1_col2_ff && m2_ff;

`ifndef SYNTHESIS
   a_no_pixel_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !ctrl.pix_accept)
      else $error("pixel accepted during line store clear");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      slot_ff != 2'd3)
      else $error("row slot out of range");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      WCW'(col_ff) < MAX_W)
      else $error("column counter beyond line store");

   a_row_saturates: assert property (@(posedge clock) disable iff (reset)
      (ctrl.pix_accept && !ctrl.first && row_ff == gdsc_pkg::ROW_SAT)
      |=> row_ff == gdsc_pkg::ROW_SAT)
      else $error("row counter left saturation");
`endif

endmodule

// ===== rtl/core/gdsc_shade.sv =====
// ----------------------------------------------------------------------------
// gdsc_shade
// Shade table (two RAM copies for four lookups per pixel) and page mux.
// ----------------------------------------------------------------------------
module gdsc_shade (
   input  logic                            clock,
   input  logic                            load_en,
   input  logic                            rd_en,
   input  gdsc_pkg::req_item_type          acc_item,
   input  gdsc_pkg::req_item_type          s1_item,
   input  logic                            shadow,
   input  logic [gdsc_pkg::LAYOUT_W-1:0]   layout_mode,
   output gdsc_pkg::rsp_item_type          pixel
);

   localparam int PW = gdsc_pkg::PIX_W;

   logic [PW-1:0] shade_a, shade_b, shade_c, shade_d;

   function automatic logic [PW-1:0] shade_or_keep(
      input logic [PW-1:0] glyph,
      input logic [PW-1:0] back,
      input logic [PW-1:0] shade,
      input logic          shd
   );
      logic [PW-1:0] res;
      if (glyph != '0) begin
         res = glyph;
      end else if (shd) begin
         res = shade;
      end else begin
         res = back;
      end
      return res;
   endfunction

   gdsc_ram #(
      .WIDTH (PW),
      .DEPTH (gdsc_pkg::SHADE_DEPTH)
   ) u_shade_ab (
      .clock     (clock),
      .wr_en     (load_en),
      .wr_addr   (acc_item.table_index),
      .wr_data   (acc_item.table_value),
      .rd_en     (rd_en),
      .rd_addr_a (acc_item.back_a),
      .rd_addr_b (acc_item.back_b),
      .rd_data_a (shade_a),
      .rd_data_b (shade_b)
   );

   gdsc_ram #(
      .WIDTH (PW),
      .DEPTH (gdsc_pkg::SHADE_DEPTH)
   ) u_shade_cd (
      .clock     (clock),
      .wr_en     (load_en),
      .wr_addr   (acc_item.table_index),
      .wr_data   (acc_item.table_value),
      .rd_en     (rd_en),
      .rd_addr_a (acc_item.back_c),
      .rd_addr_b (acc_item.back_d),
      .rd_data_a (shade_c),
      .rd_data_b (shade_d)
   );

   always_comb begin
      pixel = '0;
      case (layout_mode)
         gdsc_pkg::LAYOUT_TWO_PAGE: begin
            pixel.page_one_low = shade_or_keep(s1_item.glyph_pixel, s1_item.back_a,
                                               shade_a, shadow);
            pixel.page_two_low = shade_or_keep(s1_item.glyph_pixel, s1_item.back_b,
                                               shade_b, shadow);
         end
         gdsc_pkg::LAYOUT_HIRES: begin
            pixel.page_one_low  = shade_or_keep(s1_item.glyph_pixel, s1_item.back_a,
                                                shade_a, shadow);
            pixel.page_one_high = shade_or_keep(s1_item.glyph_pixel, s1_item.back_b,
                                                shade_b, shadow);
            pixel.page_two_low  = shade_or_keep(s1_item.glyph_pixel, s1_item.back_c,
                                                shade_c, shadow);
            pixel.page_two_high = shade_or_keep(s1_item.glyph_pixel, s1_item.back_d,
                                                shade_d, shadow);
         end
         default: begin
            // plain, and the unused mode code
            pixel.page_one_low = shade_or_keep(s1_item.glyph_pixel, s1_item.back_a,
                                               shade_a, shadow);
         end
      endcase
   end

endmodule

// ===== rtl/core/glyph_drop_shadow_compositor.sv =====
// ----------------------------------------------------------------------------
// glyph_drop_shadow_compositor
// Composites drop-shadowed glyph pixels over background bytes.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan  : valid/ready items. A pixel item (req_type 0) yields exactly
//               one rsp_chan item; a load item (req_type 1) writes one shade
//               table entry and yields nothing.
//   rsp_chan  : valid/ready composited pixel, four page bytes.
//   csr_*     : write-only registers, index 0 layout_mode, 1 glyph_width.
//               Write them only while no item is in flight.
// Timing:
//   One item per clock sustained while rsp_chan.ready is high. A pixel item
//   passes the read stage (line store / shade table read), then the output
//   register, before it reaches rsp_chan. The rate is set by the read-modify-
//   write of the edge line store, which reads and writes back the same entry in the same cycle.
// Reset:
//   Counters, valids and configuration registers reset at once; then the edge line store
//   is zeroed by a sweep over all 3*MAX_WIDTH entries (192 at the default)
//   during which req_chan.ready stays low. Shade table contents are
//   undefined until loaded.
// Stall:
//   The result sits in the output register while rsp_chan.ready is low;
//   one more item can be accepted into the read stage, then req_chan.ready
//   drops until the output register frees up.
// ----------------------------------------------------------------------------
module glyph_drop_shadow_compositor #(
   parameter int MAX_WIDTH = gdsc_pkg::MAX_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   gdsc_req_if.sink                            req_chan,
   gdsc_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [gdsc_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [gdsc_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   // configuration
   logic [gdsc_pkg::LAYOUT_W-1:0]      layout_mode_ff, layout_mode_in;
   logic [gdsc_pkg::GLYPH_WIDTH_W-1:0] glyph_width_ff, glyph_width_in;

   // read stage (S1) and output register
   logic                    s1_valid_ff, s1_valid_in;
   gdsc_pkg::req_item_type  s1_item_ff, s1_item_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   gdsc_pkg::rsp_item_type  rsp_data_ff, rsp_data_in;

   logic                        s1_advance;
   logic                        req_fire;
   logic                        pix_accept;
   logic                        load_accept;
   gdsc_pkg::raster_ctrl_type   raster_ctrl;
   gdsc_pkg::raster_status_type raster_status;
   gdsc_pkg::rsp_item_type      pixel;

   // handshake: S1 moves on when the output register is free or draining
   assign s1_advance     = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !raster_status.busy && (!s1_valid_ff || s1_advance);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign pix_accept     = req_fire && (req_chan.data.req_type == gdsc_pkg::REQ_PIXEL);
   assign load_accept    = req_fire && (req_chan.data.req_type == gdsc_pkg::REQ_LOAD);

   assign raster_ctrl.pix_accept = pix_accept;
   assign raster_ctrl.s1_advance = s1_advance;
   assign raster_ctrl.first      = req_chan.data.first_of_glyph;
   assign raster_ctrl.opaque     = (req_chan.data.glyph_pixel != '0);

   always_comb begin
      layout_mode_in = layout_mode_ff;
      glyph_width_in = glyph_width_ff;
      if (csr_wr_en) begin
         case (csr_index)
            gdsc_pkg::CSR_LAYOUT_MODE: layout_mode_in = csr_wr_data[gdsc_pkg::LAYOUT_W-1:0];
            gdsc_pkg::CSR_GLYPH_WIDTH: glyph_width_in = csr_wr_data;
            default: begin
               layout_mode_in = layout_mode_ff;
            end
         endcase
      end
   end

   // load items bypass S1: the shade write lands before any later read
   always_comb begin
      if (pix_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      s1_item_in = pix_accept ? req_chan.data : s1_item_ff;

      if (s1_advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
      rsp_data_in = s1_advance ? pixel : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_mode_ff <= gdsc_pkg::LAYOUT_PLAIN;
         glyph_width_ff <= gdsc_pkg::GLYPH_WIDTH_RESET;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         layout_mode_ff <= layout_mode_in;
         glyph_width_ff <= glyph_width_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_item_ff  <= s1_item_in;
      rsp_data_ff <= rsp_data_in;
   end

   gdsc_raster #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_raster (
      .clock       (clock),
      .reset       (reset),
      .ctrl        (raster_ctrl),
      .glyph_width (glyph_width_ff),
      .status      (raster_status)
   );

   gdsc_shade u_shade (
      .clock       (clock),
      .load_en     (load_accept),
      .rd_en       (pix_accept),
      .acc_item    (req_chan.data),
      .s1_item     (s1_item_ff),
      .shadow      (raster_status.shadow),
      .layout_mode (layout_mode_ff),
      .pixel       (pixel)
   );

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_pixel_fills_s1: assert property (@(posedge clock) disable iff (reset)
      pix_accept |=> s1_valid_ff)
      else $error("accepted pixel missing from read stage");

   a_s1_free_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |-> (!s1_valid_ff || s1_advance))
      else $error("item accepted over an occupied read stage");

   a_s1_drains_to_output: assert property (@(posedge clock) disable iff (reset)
      s1_advance |=> rsp_valid_ff)
      else $error("retired pixel not in output register");
`endif

endmodule
